// ----- rtl/flu_pkg.sv -----
package flu_pkg;

    localparam int ALPHABET = 26;
    localparam int LETTER_W = 5;

    typedef logic [LETTER_W-1:0] t_letter;

    // forward link between neighbouring cells, first cell on the left
    typedef struct packed {
        logic    hit;
        logic    prev_valid;
        logic    found;
        t_letter letter;
    } t_link;

endpackage

// ----- rtl/flu_cell.sv -----
module flu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_in_range,
    input  flu_pkg::t_letter i_letter,
    input  flu_pkg::t_link i_link,
    output flu_pkg::t_link o_link
);
    import flu_pkg::*;

    logic    r_valid;
    logic    r_dup;
    t_letter r_letter;

    logic match;
    logic append;
    logic eligible;

    assign match    = r_valid && (r_letter == i_letter);
    assign append   = !r_valid && i_link.prev_valid && !i_link.hit && i_in_range;
    assign eligible = r_valid && !r_dup;

    always_comb begin
        o_link.hit        = i_link.hit | match;
        o_link.prev_valid = r_valid;
        o_link.found      = i_link.found | eligible;
        if (i_link.found) begin
            o_link.letter = i_link.letter;
        end else if (eligible) begin
            o_link.letter = r_letter;
        end else begin
            o_link.letter = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dup   <= 1'b0;
        end else if (i_load) begin
            if (append) begin
                r_valid <= 1'b1;
                r_dup   <= 1'b0;
            end else if (match) begin
                r_dup   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && append) begin
            r_letter <= i_letter;
        end
    end

endmodule

// ----- rtl/first_unique_letter_stream_unit.sv -----
// First non-repeating letter of a stream. Each input transaction carries one
// letter index (0 = a .. 25 = z); each produces exactly one output transaction
// holding the earliest-arriving letter seen exactly once so far, or
// none_unique set with first_letter zero. Indices of 26 and above change
// nothing and return the current answer. Letters live in a row of 26 cells in
// order of first arrival; a new letter is compared in every cell and either
// marks its cell repeated or is appended at the first empty cell, and the
// answer is a priority select along the row. One item per cycle sustained
// while the output is accepted; each result passes through the cell update
// and then the select into the output register, which waits while the output is held.
// There is no clearing pass after reset.
module first_unique_letter_stream_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [4:0] letter
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [4:0] first_letter
    output logic       o_m_tuser    // [0] none_unique
);
    import flu_pkg::*;

    t_link   link [ALPHABET+1];
    t_letter in_letter;
    logic    in_range;
    logic    s_accept;
    logic    load_out;

    logic    r_pend;
    logic    n_pend;
    logic    r_ovalid;
    logic    n_ovalid;
    t_letter r_first;
    logic    r_none;

    assign in_letter = i_s_tdata[LETTER_W-1:0];
    assign in_range  = (in_letter < LETTER_W'(ALPHABET));
    assign load_out  = r_pend && (!r_ovalid || i_m_tready);
    assign o_s_tready = !r_pend || load_out;
    assign s_accept  = i_s_tvalid && o_s_tready;

    assign link[0] = '{hit: 1'b0, prev_valid: 1'b1, found: 1'b0, letter: '0};

    for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
        flu_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (s_accept),
            .i_in_range (in_range),
            .i_letter   (in_letter),
            .i_link     (link[g]),
            .o_link     (link[g+1])
        );
    end

    always_comb begin
        n_pend = r_pend;
        if (s_accept) begin
            n_pend = 1'b1;
        end else if (load_out) begin
            n_pend = 1'b0;
        end
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_first <= link[ALPHABET].found ? link[ALPHABET].letter : '0;
            r_none  <= !link[ALPHABET].found;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(8-LETTER_W){1'b0}}, r_first};
    assign o_m_tuser  = r_none;

    // no answer means a zero letter
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_none) |-> (r_first == '0))
        else $error("none_unique with non-zero letter");

    // an accepted letter always leaves a pending result
    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_pend)
        else $error("accepted letter lost its result");

    // a pending result that cannot move blocks the input
    a_pend_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !load_out) |-> !o_s_tready)
        else $error("input taken over a pending result");

    // loading the output register always presents a result next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_ovalid)
        else $error("loaded result not presented");

endmodule

// ----- bench/first_unique_letter_stream_unit_tb.sv -----
`timescale 1ns / 100ps

module first_unique_letter_stream_unit_tb;
    import flu_pkg::*;

    localparam int MAX_INDEX = (1 << LETTER_W) - 1;
    localparam int HOLD_CYCLES = 100;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct packed {
        t_letter first_letter;
        logic    none_unique;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [4:0] letter
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [4:0] first_letter
    logic       o_m_tuser;   // [0] none_unique

    bit         idle_en;
    bit         hold_req;
    int         error_count = 0;

    // predictor state
    logic [1:0] letter_seen [ALPHABET] = '{default: 2'd0};
    t_letter    arrival_seq [$];
    t_answer    predicted_answers [$];

    first_unique_letter_stream_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_answer first_unique_after(input t_letter l);
        t_answer a;
        a.first_letter = '0;
        a.none_unique  = 1'b1;
        if (l < ALPHABET) begin
            if (letter_seen[l] == 2'd0) arrival_seq.push_back(l);
            if (letter_seen[l] != 2'd2) letter_seen[l] = letter_seen[l] + 2'd1;
        end
        foreach (arrival_seq[k]) begin
            if (a.none_unique && letter_seen[arrival_seq[k]] == 2'd1) begin
                a.first_letter = arrival_seq[k];
                a.none_unique  = 1'b0;
            end
        end
        return a;
    endfunction

    task automatic send_letter(input t_letter l);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {3'b000, l};
        do @(posedge i_clk); while (!(o_s_tready === 1'b1));
        predicted_answers.push_back(first_unique_after(l));
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (predicted_answers.size() == 0) begin
                $error("result transaction with nothing outstanding");
                error_count++;
            end else begin
                t_answer want;
                want = predicted_answers.pop_front();
                if (o_m_tdata[4:0] !== want.first_letter) begin
                    $error("first_letter: expected %0d, got %0d",
                           want.first_letter, o_m_tdata[4:0]);
                    error_count++;
                end
                if (o_m_tuser !== want.none_unique) begin
                    $error("none_unique: expected %0d, got %0d",
                           want.none_unique, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    // out-of-range letters before anything has arrived
    task automatic test_empty_stream;
        send_letter(t_letter'(ALPHABET));
        send_letter(t_letter'(MAX_INDEX));
        send_letter(t_letter'(27));
    endtask

    // lowest and highest letters, repeats and saturation
    task automatic test_letter_extremes;
        send_letter(t_letter'(0));
        send_letter(t_letter'(ALPHABET - 1));
        send_letter(t_letter'(0));
        send_letter(t_letter'(29));
        send_letter(t_letter'(ALPHABET - 1));
        send_letter(t_letter'(ALPHABET - 1));
        send_letter(t_letter'(0));
        send_letter(t_letter'(MAX_INDEX));
    endtask

    // remaining letters each twice in shuffled order, filling the order store
    task automatic test_order_store_fill;
        int pairs [48];
        int j;
        int tmp;
        for (int k = 0; k < 48; k++) pairs[k] = 1 + k / 2;
        for (int k = 47; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = pairs[k];
            pairs[k] = pairs[j];
            pairs[j] = tmp;
        end
        for (int k = 0; k < 48; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_letter(t_letter'($urandom_range(ALPHABET, MAX_INDEX)));
            send_letter(t_letter'(pairs[k]));
        end
    endtask

    // receiver holds off while letters keep coming
    task automatic test_output_backpressure;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) send_letter(t_letter'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic test_random_stream;
        for (int k = 0; k < RANDOM_ITEMS; k++)
            send_letter(t_letter'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic test_back_to_back;
        idle_en = 1'b0;
        for (int k = 0; k < 50; k++) send_letter(t_letter'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic finish_run;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (predicted_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_stream;
        test_letter_extremes;
        test_order_store_fill;
        test_output_backpressure;
        test_random_stream;
        test_back_to_back;
        finish_run;
    end

endmodule
